// ===== rtl/core/clfp_pkg.sv =====
// Shared types, constants and digit decode for the command line field parser.
`timescale 1ns / 1ps
`default_nettype none

package clfp_pkg;

  localparam int unsigned MaxFieldsDef = 16;
  localparam int unsigned NibMax       = 8;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2E;

  typedef struct packed {
    logic        start;
    logic [31:0] acc;
    logic [3:0]  ndig;
  } dec_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
    logic        err;
  } dec_rsp_t;

  typedef struct packed {
    logic       is_dig;
    logic       bad;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t digit_of(input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] k;
    digit_t     r;
    c = (b >= 8'h61) ? b - 8'h20 : b;
    k = '0;
    r = '0;
    if (c >= 8'h30) begin
      k = (c < 8'h41) ? c - 8'h30 : c - 8'h37;
      if (k > 8'd15) begin
        r.bad = 1'b1;
      end else begin
        r.is_dig = 1'b1;
        r.val    = k[3:0];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/command_line_field_parser_unit.sv =====
// Top level of the command line field parser: byte sequencer, field state and result register.
//
//   channel | direction | signals                               | transaction
//   --------+-----------+---------------------------------------+-------------------------
//   in      | input     | in_valid_i, in_ready_o, char_byte_i   | one line byte
//   out     | output    | out_valid_o, out_ready_i, result ports| field value or summary
//
// A byte is registered in S_IDLE and processed in S_EXEC; when it yields no result the
// unit returns to S_IDLE. Closing a decimal field runs the converter one nibble per cycle.
// Each result is held until taken.
// The input is not ready until all results of the previous byte are taken.
// Reset returns to the start of a line with a previous field count of zero.
`timescale 1ns / 1ps
`default_nettype none

module command_line_field_parser_unit #(
  parameter int unsigned MaxFields = clfp_pkg::MaxFieldsDef,
  localparam int unsigned CntW     = $clog2(MaxFields + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      char_byte_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 result_kind_o,
  output logic [CntW-1:0]      field_index_o,
  output logic [31:0]          field_value_o,
  output logic [15:0]          command_id_o,
  output logic [CntW-1:0]      field_count_o,
  output logic                 line_error_o,
  output logic                 repeat_line_o,
  output logic                 last_of_line_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DEC,
    S_OUT_FLD,
    S_OUT_SUM
  } state_e;

  typedef enum logic [1:0] {
    LP_START,
    LP_LINE,
    LP_REPEAT
  } lphase_e;

  typedef enum logic [1:0] {
    DP_SKIP,
    DP_DIGITS,
    DP_DONE
  } dphase_e;

  localparam logic [1:0] CmdDone = 2'd2;
  localparam logic [3:0] NibMaxW = 4'(clfp_pkg::NibMax);

  state_e              state_q, state_d;
  lphase_e             lphase_q, lphase_d;
  dphase_e             dphase_q, dphase_d;
  logic [7:0]          byte_q, byte_d;
  logic [CntW-1:0]     fields_q, fields_d;
  logic [CntW-1:0]     prev_q, prev_d;
  logic                inside_q, inside_d;
  logic [15:0]         cmd_q, cmd_d;
  logic [1:0]          cbytes_q, cbytes_d;
  logic [31:0]         val_q, val_d;
  logic [3:0]          ndig_q, ndig_d;
  logic                dot_q, dot_d;
  logic                err_q, err_d;
  logic                excess_q, excess_d;
  logic                sum_pend_q, sum_pend_d;
  logic                sum_rep_q, sum_rep_d;
  logic [31:0]         res_val_q, res_val_d;

  logic                go_line;
  logic                fld_emit;
  logic                fld_dec;
  logic                sum_emit;
  logic                sum_rep;
  clfp_pkg::digit_t    dig;
  clfp_pkg::dec_req_t  dec_req;
  clfp_pkg::dec_rsp_t  dec_rsp;

  assign dig = clfp_pkg::digit_of(byte_q);

  clfp_dec_unit u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dec_req),
    .rsp_o  (dec_rsp)
  );

  always_comb begin
    state_d    = state_q;
    lphase_d   = lphase_q;
    dphase_d   = dphase_q;
    byte_d     = byte_q;
    fields_d   = fields_q;
    prev_d     = prev_q;
    inside_d   = inside_q;
    cmd_d      = cmd_q;
    cbytes_d   = cbytes_q;
    val_d      = val_q;
    ndig_d     = ndig_q;
    dot_d      = dot_q;
    err_d      = err_q;
    excess_d   = excess_q;
    sum_pend_d = sum_pend_q;
    sum_rep_d  = sum_rep_q;
    res_val_d  = res_val_q;
    go_line    = 1'b0;
    fld_emit   = 1'b0;
    fld_dec    = 1'b0;
    sum_emit   = 1'b0;
    sum_rep    = 1'b0;
    dec_req.start = 1'b0;
    dec_req.acc   = val_q;
    dec_req.ndig  = ndig_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          byte_d  = char_byte_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (lphase_q == LP_START) begin
          if (byte_q < clfp_pkg::ChSpace) begin
            if (byte_q == clfp_pkg::ChNul) begin
              sum_emit = 1'b1;
              sum_rep  = 1'b1;
            end else begin
              lphase_d = LP_REPEAT;
            end
          end else begin
            go_line  = 1'b1;
            lphase_d = LP_LINE;
            fields_d = '0;
            inside_d = 1'b0;
            cmd_d    = '0;
            cbytes_d = '0;
            err_d    = 1'b0;
            excess_d = 1'b0;
          end
        end else if (lphase_q == LP_REPEAT) begin
          if (byte_q == clfp_pkg::ChNul) begin
            lphase_d = LP_START;
            sum_emit = 1'b1;
            sum_rep  = 1'b1;
          end
        end else begin
          go_line = 1'b1;
        end

        if (go_line) begin
          if (byte_q == clfp_pkg::ChNul || byte_q == clfp_pkg::ChSpace) begin
            if (inside_d) begin
              inside_d = 1'b0;
              if (!excess_d && fields_d >= CntW'(2)) begin
                if (dot_d) begin
                  fld_dec = 1'b1;
                end else begin
                  fld_emit = 1'b1;
                end
              end
            end
            if (byte_q == clfp_pkg::ChNul) begin
              prev_d   = fields_d;
              sum_emit = 1'b1;
              lphase_d = LP_START;
            end
          end else begin
            if (!inside_d) begin
              dphase_d = DP_SKIP;
              val_d    = '0;
              ndig_d   = '0;
              dot_d    = 1'b0;
              inside_d = 1'b1;
              if (fields_d < CntW'(MaxFields)) begin
                fields_d = fields_d + CntW'(1);
                excess_d = 1'b0;
              end else begin
                excess_d = 1'b1;
                err_d    = 1'b1;
              end
            end
            if (!excess_d) begin
              if (fields_d == CntW'(1)) begin
                if (cbytes_d != CmdDone) begin
                  if (byte_q == clfp_pkg::ChNl) begin
                    cbytes_d = CmdDone;
                  end else begin
                    cmd_d    = {cmd_d[7:0], byte_q};
                    cbytes_d = cbytes_d + 2'd1;
                  end
                end
              end else if (dphase_d != DP_DONE) begin
                if (dig.bad) begin
                  err_d = 1'b1;
                end
                if (dig.is_dig) begin
                  val_d = (dphase_d == DP_SKIP) ? {28'b0, dig.val} : {val_d[27:0], dig.val};
                  if (ndig_d < NibMaxW) begin
                    ndig_d = ndig_d + 4'd1;
                  end
                  dphase_d = DP_DIGITS;
                end else if (dphase_d == DP_DIGITS) begin
                  dphase_d = DP_DONE;
                  dot_d    = (byte_q == clfp_pkg::ChDot);
                end
              end
            end
          end
        end

        sum_pend_d = sum_emit;
        sum_rep_d  = sum_rep;
        if (fld_dec) begin
          dec_req.start = 1'b1;
          state_d       = S_DEC;
        end else if (fld_emit) begin
          res_val_d = val_q;
          state_d   = S_OUT_FLD;
        end else if (sum_emit) begin
          state_d = S_OUT_SUM;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_DEC: begin
        if (dec_rsp.done) begin
          res_val_d = dec_rsp.value;
          if (dec_rsp.err) begin
            err_d = 1'b1;
          end
          state_d = S_OUT_FLD;
        end
      end

      S_OUT_FLD: begin
        if (out_ready_i) begin
          state_d = sum_pend_q ? S_OUT_SUM : S_IDLE;
        end
      end

      S_OUT_SUM: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      lphase_q   <= LP_START;
      dphase_q   <= DP_SKIP;
      byte_q     <= '0;
      fields_q   <= '0;
      prev_q     <= '0;
      inside_q   <= 1'b0;
      cmd_q      <= '0;
      cbytes_q   <= '0;
      val_q      <= '0;
      ndig_q     <= '0;
      dot_q      <= 1'b0;
      err_q      <= 1'b0;
      excess_q   <= 1'b0;
      sum_pend_q <= 1'b0;
      sum_rep_q  <= 1'b0;
      res_val_q  <= '0;
    end else begin
      state_q    <= state_d;
      lphase_q   <= lphase_d;
      dphase_q   <= dphase_d;
      byte_q     <= byte_d;
      fields_q   <= fields_d;
      prev_q     <= prev_d;
      inside_q   <= inside_d;
      cmd_q      <= cmd_d;
      cbytes_q   <= cbytes_d;
      val_q      <= val_d;
      ndig_q     <= ndig_d;
      dot_q      <= dot_d;
      err_q      <= err_d;
      excess_q   <= excess_d;
      sum_pend_q <= sum_pend_d;
      sum_rep_q  <= sum_rep_d;
      res_val_q  <= res_val_d;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = (state_q == S_OUT_FLD) || (state_q == S_OUT_SUM);
  assign result_kind_o  = (state_q == S_OUT_SUM);
  assign last_of_line_o = (state_q == S_OUT_SUM);
  assign field_index_o  = (state_q == S_OUT_FLD) ? fields_q - CntW'(1) : '0;
  assign field_value_o  = (state_q == S_OUT_FLD) ? res_val_q : '0;
  assign command_id_o   = (state_q == S_OUT_SUM && !sum_rep_q) ? cmd_q : '0;
  assign field_count_o  = (state_q == S_OUT_SUM) ? prev_q : '0;
  assign line_error_o   = (state_q == S_OUT_SUM) && !sum_rep_q && err_q;
  assign repeat_line_o  = (state_q == S_OUT_SUM) && sum_rep_q;

endmodule

`default_nettype wire

// ===== rtl/core/clfp_dec_unit.sv =====
// Iterative decimal-nibble-to-binary converter, one nibble per cycle with a shared times-ten add.
`timescale 1ns / 1ps
`default_nettype none

module clfp_dec_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire clfp_pkg::dec_req_t req_i,
  output clfp_pkg::dec_rsp_t      rsp_o
);

  localparam logic [3:0] NibMaxW = 4'(clfp_pkg::NibMax);

  logic        busy_q, busy_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] sh_q, sh_d;
  logic [31:0] val_q, val_d;
  logic        err_q, err_d;
  logic [3:0]  nib;
  logic [5:0]  shamt;
  logic [31:0] step_val;

  assign nib      = sh_q[31:28];
  assign shamt    = {NibMaxW - req_i.ndig, 2'b00};
  assign step_val = (val_q << 3) + (val_q << 1) + {28'b0, nib};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    val_d  = val_q;
    err_d  = err_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.ndig;
      sh_d   = req_i.acc << shamt;
      val_d  = '0;
      err_d  = 1'b0;
    end else if (busy_q) begin
      if (cnt_q != 4'd0) begin
        val_d = step_val;
        err_d = err_q | (nib > 4'd9);
        sh_d  = sh_q << 4;
        cnt_d = cnt_q - 4'd1;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    val_q <= val_d;
    err_q <= err_d;
  end

  assign rsp_o.done  = busy_q && (cnt_q == 4'd0);
  assign rsp_o.value = val_q;
  assign rsp_o.err   = err_q;

endmodule

`default_nettype wire

// ===== test/command_line_field_parser_unit_tb.sv =====
// Self-checking testbench for the command line field parser unit.
`timescale 1ns / 1ps

module command_line_field_parser_unit_tb;

  localparam int unsigned MAX_FIELDS   = clfp_pkg::MaxFieldsDef;
  localparam int          TOTAL_BYTES  = 1650;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          QUIET_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          NOT_DIGIT    = -1;
  localparam int          BAD_DIGIT    = -2;

  localparam logic KIND_FIELD   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {LINE_START, LINE_NORMAL, LINE_REPEAT} line_state_e;
  typedef enum logic [1:0] {NUM_SKIP, NUM_DIGITS, NUM_DONE} num_state_e;

  typedef struct packed {
    logic        kind;
    logic [4:0]  index;
    logic [31:0] value;
    logic [15:0] command;
    logic [4:0]  count;
    logic        line_error;
    logic        repeat_line;
    logic        last_of_line;
  } parse_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  char_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        result_kind_o;
  logic [4:0]  field_index_o;
  logic [31:0] field_value_o;
  logic [15:0] command_id_o;
  logic [4:0]  field_count_o;
  logic        line_error_o;
  logic        repeat_line_o;
  logic        last_of_line_o;

  parse_result_t expected_results[$];
  int            mismatches  = 0;
  int            bytes_sent  = 0;
  int            pending_gap = 0;
  bit            fast_mode   = 1'b0;
  bit            hold_off_req = 1'b0;

  line_state_e line_state  = LINE_START;
  num_state_e  num_state   = NUM_SKIP;
  logic [4:0]  prev_count  = '0;
  logic [4:0]  fields_seen = '0;
  logic        in_field    = 1'b0;
  logic [15:0] cmd_acc     = '0;
  logic [1:0]  cmd_bytes   = '0;
  logic [31:0] num_acc     = '0;
  logic [3:0]  num_digits  = '0;
  logic        dot_end     = 1'b0;
  logic        line_err    = 1'b0;
  logic        excess      = 1'b0;

  command_line_field_parser_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_byte_i    (char_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .field_index_o  (field_index_o),
    .field_value_o  (field_value_o),
    .command_id_o   (command_id_o),
    .field_count_o  (field_count_o),
    .line_error_o   (line_error_o),
    .repeat_line_o  (repeat_line_o),
    .last_of_line_o (last_of_line_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int nibble_of(input logic [7:0] b);
    if (b < "0") return NOT_DIGIT;
    if (b <= "?") return int'(b - "0");
    if ((b >= "A" && b <= "F") || (b >= "a" && b <= "f")) return int'(b[2:0]) + 9;
    return BAD_DIGIT;
  endfunction

  function automatic logic [31:0] bcd_value(input logic [31:0] nibbles, input logic [3:0] n);
    logic [31:0] sum;
    logic [31:0] weight;
    logic [3:0]  t;
    sum = '0;
    weight = 32'd1;
    for (int k = 0; k < n && k < 8; k++) begin
      t = nibbles[3:0];
      if (t > 4'd9) line_err = 1'b1;
      sum = sum + t * weight;
      nibbles = nibbles >> 4;
      weight = weight * 32'd10;
    end
    return sum;
  endfunction

  function automatic void expect_summary(input logic [15:0] cmd, input logic [4:0] cnt,
                                         input logic err, input logic rep);
    parse_result_t r;
    r = '0;
    r.kind = KIND_SUMMARY;
    r.command = cmd;
    r.count = cnt;
    r.line_error = err;
    r.repeat_line = rep;
    r.last_of_line = 1'b1;
    expected_results.push_back(r);
  endfunction

  function automatic void close_param();
    parse_result_t r;
    in_field = 1'b0;
    if (excess || fields_seen < 5'd2) return;
    r = '0;
    r.kind = KIND_FIELD;
    r.index = fields_seen - 5'd1;
    r.value = dot_end ? bcd_value(num_acc, num_digits) : num_acc;
    expected_results.push_back(r);
  endfunction

  function automatic void open_field();
    num_state = NUM_SKIP;
    num_acc = '0;
    num_digits = '0;
    dot_end = 1'b0;
    in_field = 1'b1;
    if (fields_seen < MAX_FIELDS) begin
      fields_seen++;
      excess = 1'b0;
    end else begin
      excess = 1'b1;
      line_err = 1'b1;
    end
  endfunction

  function automatic void field_char(input logic [7:0] b);
    int         nib;
    logic [3:0] nv;
    if (excess) return;
    if (fields_seen == 5'd1) begin
      if (cmd_bytes < 2'd2) begin
        if (b == clfp_pkg::ChNl) begin
          cmd_bytes = 2'd2;
        end else begin
          cmd_acc = {cmd_acc[7:0], b};
          cmd_bytes++;
        end
      end
      return;
    end
    if (num_state == NUM_DONE) return;
    nib = nibble_of(b);
    if (nib == BAD_DIGIT) line_err = 1'b1;
    if (nib >= 0) begin
      nv = nib[3:0];
      num_acc = (num_state == NUM_SKIP) ? {28'd0, nv} : {num_acc[27:0], nv};
      if (num_digits < 4'd8) num_digits++;
      num_state = NUM_DIGITS;
    end else if (num_state == NUM_DIGITS) begin
      num_state = NUM_DONE;
      dot_end = (b == clfp_pkg::ChDot);
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    if (line_state == LINE_START) begin
      if (b < clfp_pkg::ChSpace) begin
        if (b == clfp_pkg::ChNul) begin
          expect_summary('0, prev_count, 1'b0, 1'b1);
          return;
        end
        line_state = LINE_REPEAT;
        return;
      end
      line_state = LINE_NORMAL;
      fields_seen = '0;
      in_field = 1'b0;
      cmd_acc = '0;
      cmd_bytes = '0;
      line_err = 1'b0;
      excess = 1'b0;
    end
    if (line_state == LINE_REPEAT) begin
      if (b != clfp_pkg::ChNul) return;
      line_state = LINE_START;
      expect_summary('0, prev_count, 1'b0, 1'b1);
      return;
    end
    if (b == clfp_pkg::ChNul) begin
      if (in_field) close_param();
      prev_count = fields_seen;
      expect_summary(cmd_acc, fields_seen, line_err, 1'b0);
      line_state = LINE_START;
      return;
    end
    if (b == clfp_pkg::ChSpace) begin
      if (in_field) close_param();
      return;
    end
    if (!in_field) open_field();
    field_char(b);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    repeat (pending_gap) @(posedge clk_i);
    in_valid_i  <= 1'b1;
    char_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    parse_byte(b);
    bytes_sent++;
    pending_gap = fast_mode ? 0 : $urandom_range(0, 15);
    if (pending_gap != 0) in_valid_i <= 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_digit();
    int k;
    k = $urandom_range(0, 27);
    if (k < 16) return 8'(8'h30 + k);
    if (k < 22) return 8'(8'h41 + k - 16);
    return 8'(8'h61 + k - 22);
  endfunction

  function automatic logic [7:0] pick_non_digit();
    case ($urandom_range(0, 15))
      0:       return 8'($urandom_range(8'h67, 8'hFF));
      1:       return 8'($urandom_range(8'h47, 8'h60));
      2:       return 8'h40;
      3:       return 8'($urandom_range(8'h01, 8'h1F));
      default: return 8'($urandom_range(8'h21, 8'h2F));
    endcase
  endfunction

  function automatic logic [7:0] pick_junk();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    return (b == clfp_pkg::ChSpace) ? 8'h21 : b;
  endfunction

  task automatic send_param();
    int n_pre;
    int n_dig;
    bit dec;
    n_pre = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    n_dig = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
    dec   = ($urandom_range(0, 2) == 0);
    repeat (n_pre) send_byte(pick_non_digit());
    repeat (n_dig) begin
      if (dec && $urandom_range(0, 7) != 0) send_byte(8'(8'h30 + $urandom_range(0, 9)));
      else send_byte(pick_digit());
    end
    if (dec) begin
      send_byte(clfp_pkg::ChDot);
    end else if ($urandom_range(0, 3) == 0) begin
      send_byte(pick_non_digit());
    end
    if ($urandom_range(0, 5) == 0) send_byte(pick_junk());
  endtask

  task automatic send_line(input int n_params);
    int n_cmd;
    if ($urandom_range(0, 7) == 0) send_byte(clfp_pkg::ChSpace);
    n_cmd = $urandom_range(1, 3);
    send_byte(8'($urandom_range(8'h21, 8'hFF)));
    for (int i = 1; i < n_cmd; i++) begin
      if ($urandom_range(0, 5) == 0) send_byte(clfp_pkg::ChNl);
      else send_byte(8'($urandom_range(8'h21, 8'hFF)));
    end
    repeat (n_params) begin
      repeat ($urandom_range(0, 3) == 0 ? 2 : 1) send_byte(clfp_pkg::ChSpace);
      send_param();
    end
    if ($urandom_range(0, 3) == 0) send_byte(clfp_pkg::ChSpace);
    send_byte(clfp_pkg::ChNul);
  endtask

  task automatic test_directed_lines();
    send_byte(clfp_pkg::ChNul);
    send_byte(8'h01);
    send_text("zz");
    send_byte(clfp_pkg::ChNul);
    send_text("  ");
    send_byte(clfp_pkg::ChNul);
    send_text("Q\n ffffffff x1G 99.");
    send_byte(clfp_pkg::ChNul);
    send_text("zy ~A. 123456789");
    send_byte(8'hFF);
    send_byte(clfp_pkg::ChNul);
  endtask

  task automatic test_back_to_back();
    fast_mode = 1'b1;
    repeat (6) send_line($urandom_range(1, 4));
    fast_mode = 1'b0;
  endtask

  task automatic test_output_backpressure();
    hold_off_req = 1'b1;
    send_line(8);
  endtask

  task automatic test_too_many_fields();
    repeat (2) send_line($urandom_range(MAX_FIELDS, MAX_FIELDS + 3));
  endtask

  task automatic test_random_lines();
    int choice;
    while (bytes_sent < TOTAL_BYTES) begin
      choice = $urandom_range(0, 19);
      if (choice == 0) begin
        repeat ($urandom_range(0, 10)) send_byte(8'($urandom_range(1, 255)));
        send_byte(clfp_pkg::ChNul);
      end else if (choice <= 2) begin
        send_byte(8'($urandom_range(1, 31)));
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(1, 255)));
        send_byte(clfp_pkg::ChNul);
      end else if (choice == 3) begin
        repeat ($urandom_range(1, 3)) send_byte(clfp_pkg::ChSpace);
        send_byte(clfp_pkg::ChNul);
      end else if (choice == 4) begin
        send_line($urandom_range(MAX_FIELDS - 1, MAX_FIELDS + 3));
      end else begin
        send_line($urandom_range(0, 5));
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    parse_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", want.kind, result_kind_o);
        check_field("field_index", want.index, field_index_o);
        check_field("field_value", want.value, field_value_o);
        check_field("command_id", want.command, command_id_o);
        check_field("field_count", want.count, field_count_o);
        check_field("line_error", want.line_error, line_error_o);
        check_field("repeat_line", want.repeat_line, repeat_line_o);
        check_field("last_of_line", want.last_of_line, last_of_line_o);
      end
    end
  end

  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        stall = fast_mode ? 0 : $urandom_range(0, 15);
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i) && !hold_off_req);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("command_line_field_parser_unit test failed");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_byte_i = 8'h00;
    pending_gap = $urandom_range(0, 15);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_lines();
    test_back_to_back();
    test_output_backpressure();
    test_too_many_fields();
    test_random_lines();
    if (pending_gap == 0) in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("command_line_field_parser_unit test passed");
    end else begin
      $display("command_line_field_parser_unit test failed");
    end
    $finish;
  end

endmodule
